FILE: src/pfa_pkg.sv
// Shared types, constants and codes for the partition fit allocator.
package pfa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_POLICY    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic OPC_LOAD    = 1'b0;
  localparam logic OPC_REQUEST = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  block_index;
    logic [15:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_block;
    logic [15:0] chosen_block_size;
    logic [15:0] fragment;
  } out_item_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_REQUEST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [IDX_BITS-1:0]   index;
    logic [SIZE_BITS-1:0]  size;
  } cmd_t;

endpackage

FILE: src/pfa_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
module pfa_front import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output cmd_t     q_cmd
);

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  cmd_t                 queue_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] fill_r, fill_nxt;
  cmd_t                 cmd;
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign in_stall = (fill_r == QCNT_BITS'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  // Loads naming a partition beyond the table are dropped here.
  always_comb begin
    cmd.kind  = (in_data.opcode == OPC_REQUEST) ? CMD_REQUEST : CMD_LOAD;
    cmd.index = in_data.block_index[IDX_BITS-1:0];
    cmd.size  = in_data.size_value[SIZE_BITS-1:0];
    push      = accept &&
                ((cmd.kind == CMD_REQUEST) ||
                 ({1'b0, in_data.block_index} < 5'(NUM_BLOCKS)));
  end

  assign q_valid = (fill_r != '0);
  assign q_cmd   = queue_r[rd_ptr_r];
  assign pop     = q_valid && q_take;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: src/pfa_back.sv
// Back end: partition table, serial fit search and the result register.
module pfa_back import pfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_take,
  input  cmd_t                     q_cmd,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                state_r;
  logic [1:0]            policy_cfg_r;
  logic [4:0]            blocks_cfg_r;
  logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] used_r;
  logic [IDX_BITS-1:0]   next_ptr_r;

  logic [1:0]            pol_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [CNT_BITS-1:0]   step_r;
  logic [IDX_BITS-1:0]   idx_r;
  logic [SIZE_BITS-1:0]  req_r;
  logic                  found_r;
  logic [IDX_BITS-1:0]   pick_r;
  logic [SIZE_BITS-1:0]  pick_size_r;
  logic [SIZE_BITS-1:0]  best_left_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [CNT_BITS-1:0]   eff_cnt;
  logic [1:0]            eff_pol;
  logic [SIZE_BITS-1:0]  cur_size;
  logic [SIZE_BITS-1:0]  left;
  logic                  fit;
  logic                  last;
  logic                  out_free;
  logic                  mem_we;

  always_comb begin
    eff_cnt  = (blocks_cfg_r > 5'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS)
                                                : CNT_BITS'(blocks_cfg_r);
    eff_pol  = (policy_cfg_r == POL_NEXT || policy_cfg_r == POL_WORST) ? policy_cfg_r
                                                                       : POL_FIRST;
    cur_size = size_mem[idx_r];
    left     = cur_size - req_r;
    fit      = !used_r[idx_r] && (cur_size >= req_r);
    last     = (step_r == cnt_r - CNT_BITS'(1));
    out_free = !out_valid_r || !out_stall;
    q_take   = (state_r == ST_IDLE);
    mem_we   = q_valid && q_take && (q_cmd.kind == CMD_LOAD);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[q_cmd.index] <= q_cmd.size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_cfg_r <= POL_FIRST;
      blocks_cfg_r <= 5'(NUM_BLOCKS);
      used_r       <= '0;
      next_ptr_r   <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_POLICY) begin
          policy_cfg_r <= cfg_data[1:0];
        end else if (cfg_index == CFG_BLOCKS_IN_USE) begin
          blocks_cfg_r <= cfg_data[4:0];
        end
      end

      // In the final step the result register is reloaded instead.
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == CMD_LOAD) begin
              used_r[q_cmd.index] <= 1'b0;
            end else begin
              req_r   <= q_cmd.size;
              pol_r   <= eff_pol;
              cnt_r   <= eff_cnt;
              found_r <= 1'b0;
              step_r  <= '0;
              if (eff_pol == POL_NEXT && CNT_BITS'(next_ptr_r) < eff_cnt) begin
                idx_r <= next_ptr_r;
              end else begin
                idx_r <= '0;
              end
              // An empty search range refuses at once.
              state_r <= (eff_cnt == '0) ? ST_FINISH : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fit && pol_r != POL_WORST) begin
            found_r     <= 1'b1;
            pick_r      <= idx_r;
            pick_size_r <= cur_size;
            best_left_r <= left;
            state_r     <= ST_FINISH;
          end else begin
            if (fit && (!found_r || left > best_left_r)) begin
              found_r     <= 1'b1;
              pick_r      <= idx_r;
              pick_size_r <= cur_size;
              best_left_r <= left;
            end
            if (last) begin
              state_r <= ST_FINISH;
            end else begin
              step_r <= step_r + CNT_BITS'(1);
              if (CNT_BITS'(idx_r) == cnt_r - CNT_BITS'(1)) begin
                idx_r <= '0;
              end else begin
                idx_r <= idx_r + IDX_BITS'(1);
              end
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (found_r) begin
              out_r.granted           <= 1'b1;
              out_r.chosen_block      <= 4'(pick_r);
              out_r.chosen_block_size <= 16'(pick_size_r);
              out_r.fragment          <= 16'(best_left_r);
              used_r[pick_r]          <= 1'b1;
              if (pol_r == POL_NEXT) begin
                next_ptr_r <= pick_r;
              end
            end else begin
              out_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/partition_fit_allocator_unit.sv
// Top level of the partition fit allocator: front queue, search engine and ports.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall  in_item_t: opcode, block_index, size_value
//   out_      output     out_valid/out_stall out_item_t: granted, chosen_block,
//                                           chosen_block_size, fragment
//   cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An accepted transaction is registered in the front queue and passes to the back end
// once that is idle. A load is done in the idle state and yields no result. A request
// is taken in the idle state; the search then examines N partitions (at most
// blocks_in_use, capped at 16) through a single compare unit, and the finish state
// loads the result register as soon as no earlier result is held back by out_stall.
// Reset is synchronous and active low; it frees every partition, clears the
// next-fit pointer and sets first fit over all sixteen partitions.
// While the back end searches or a result waits under out_stall, the two-entry
// front queue takes up to two more transactions and then raises in_stall.
module partition_fit_allocator_unit import pfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic q_valid;
  logic q_take;
  cmd_t q_cmd;

  // Register writes are taken in any cycle; software must write only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  pfa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_cmd    (q_cmd)
  );

  pfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_cmd     (q_cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/partition_fit_allocator_unit_test.sv
// Self-checking testbench for the partition fit allocator top level.
//
// What is covered:
//   A short table of directed transactions runs first. It holds the field
//   extremes, all three placement policies and the spare policy code. It also
//   covers a zero partition count, a refused request and a stale next-fit
//   pointer. Where the outcome is obvious, a row carries its expected grant
//   typed in. Every other row is checked against the predictor below.
//   The random part then loads every partition, so that no search can ever
//   touch a partition that was never written. After that it runs phases of
//   mixed loads and requests, and each phase has a fresh policy and
//   partition count.
//
// How it is checked:
//   The predictor is a behavioural copy of the allocator. It keeps its own
//   partition sizes, used flags, next-fit pointer and register values. Every
//   accepted request queues the grant that it should produce. Every result
//   that the block hands over is compared field by field with the oldest
//   queued grant. Loads produce nothing, so before each register write the
//   bench waits for the queue to empty. It then waits a settling time as well, so
//   that a trailing load has left the back end.
//
// Both sides idle at random. The sender draws a random gap before each
// transaction. The receiver draws a random stall for each result. Calm
// stretches with no idling at all are mixed in.
module partition_fit_allocator_unit_test;
  import pfa_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  // Settling time after the last grant, so that a trailing load has left the back end.
  localparam int SETTLE_CYCLES  = 24;
  localparam int ITEM_TARGET    = 530;
  localparam int TIMEOUT_CYCLES = 400000;

  // Policy code left unused by the package; the block treats it as first fit.
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam out_item_t REFUSED = '0;

  // One row of the directed table: either a register write or a transaction,
  // optionally with the grant that it must produce.
  typedef struct packed {
    logic                     is_cfg;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    in_item_t                 item;
    logic                     has_lit;
    out_item_t                lit;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Literal expectation travelling alongside the transaction on the input.
  logic      lit_on = 1'b0;
  out_item_t lit_grant = '0;

  // Predictor state as reset leaves it; the sizes, not reset, start at zero.
  logic [SIZE_BITS-1:0]     part_size [NUM_BLOCKS];
  bit                       part_taken [NUM_BLOCKS];
  logic [IDX_BITS-1:0]      nf_ptr = '0;
  logic [1:0]               policy = POL_FIRST;
  logic [CFG_DATA_BITS-1:0] blocks_cfg = CFG_DATA_BITS'(NUM_BLOCKS);

  out_item_t grants_due [$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        calm_tx = 1'b0;

  partition_fit_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    foreach (part_taken[b]) part_taken[b] = 1'b0;
    foreach (part_size[b]) part_size[b] = '0;
  end

  // A partition fits when it is free and at least as large as the request.
  function automatic bit fits(input int unsigned idx, input logic [SIZE_BITS-1:0] req);
    return !part_taken[idx] && part_size[idx] >= req;
  endfunction

  // Applies one transaction to the predictor state. Returns 1 when the
  // transaction produces a grant record, and that record is placed in res.
  function automatic bit allocate_item(input in_item_t it, output out_item_t res);
    int unsigned         span;
    int unsigned         start;
    int unsigned         idx;
    int unsigned         pick;
    int unsigned         i;
    logic [SIZE_BITS-1:0] left;
    logic [SIZE_BITS-1:0] widest;
    bit                  hit;
    res = '0;
    hit = 1'b0;
    pick = 0;
    widest = '0;
    span = (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : blocks_cfg;
    if (it.opcode == OPC_LOAD) begin
      part_size[it.block_index] = it.size_value;
      part_taken[it.block_index] = 1'b0;
      return 1'b0;
    end
    if (policy == POL_NEXT) begin
      // A pointer beyond the current partition count restarts the search at zero.
      start = (nf_ptr < span) ? nf_ptr : 0;
      for (i = 0; i < span && !hit; i++) begin
        idx = start + i;
        if (idx >= span) idx -= span;
        if (fits(idx, it.size_value)) begin
          pick = idx;
          hit = 1'b1;
        end
      end
      if (hit) nf_ptr = IDX_BITS'(pick);
    end else if (policy == POL_WORST) begin
      // Only a strictly larger leftover displaces the earlier candidate.
      for (i = 0; i < span; i++) begin
        if (fits(i, it.size_value)) begin
          left = part_size[i] - it.size_value;
          if (!hit || left > widest) begin
            widest = left;
            pick = i;
            hit = 1'b1;
          end
        end
      end
    end else begin
      for (i = 0; i < span && !hit; i++) begin
        if (fits(i, it.size_value)) begin
          pick = i;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      part_taken[pick] = 1'b1;
      res.granted = 1'b1;
      res.chosen_block = IDX_BITS'(pick);
      res.chosen_block_size = part_size[pick];
      res.fragment = part_size[pick] - it.size_value;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Everything is sampled at the rising edge. The bench drives with
  // nonblocking assignments, so it always sees the values from before the edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t guess;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_POLICY) policy = cfg_data[1:0];
        else if (cfg_index == CFG_BLOCKS_IN_USE) blocks_cfg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending, expected nothing, actual %p",
                   $time, out_data);
        end else begin
          want = grants_due.pop_front();
          check_field("granted", 32'(want.granted), 32'(out_data.granted));
          check_field("chosen_block", 32'(want.chosen_block), 32'(out_data.chosen_block));
          check_field("chosen_block_size", 32'(want.chosen_block_size),
                      32'(out_data.chosen_block_size));
          check_field("fragment", 32'(want.fragment), 32'(out_data.fragment));
        end
      end
      if (in_valid && !in_stall) begin
        if (allocate_item(in_data, guess)) grants_due.push_back(lit_on ? lit_grant : guess);
      end
    end
  end

  // Receiver: a fresh stall length for every result, with calm stretches.
  initial begin
    int n;
    int served;
    bit calm_rx;
    served = 0;
    calm_rx = 1'b0;
    forever begin
      if (served % 32 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      n = calm_rx ? 0 : $urandom_range(0, 12);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
      served++;
    end
  end

  // Lowers the input valid, then waits until every queued grant has arrived
  // and any trailing load has had time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (grants_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offers one transaction after a random gap and holds it until accepted.
  // The valid stays high afterwards, so the next call may follow without a gap.
  task automatic send(input in_item_t it, input bit has_lit, input out_item_t lit);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    lit_on <= has_lit;
    lit_grant <= lit;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic step_t cf(input logic [CFG_IDX_BITS-1:0] r,
                               input logic [CFG_DATA_BITS-1:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = r;
    s.reg_val = v;
    return s;
  endfunction

  function automatic step_t ld(input logic [IDX_BITS-1:0] idx,
                               input logic [SIZE_BITS-1:0] sz);
    step_t s;
    s = '0;
    s.item.opcode = OPC_LOAD;
    s.item.block_index = idx;
    s.item.size_value = sz;
    return s;
  endfunction

  function automatic step_t rq(input logic [SIZE_BITS-1:0] sz);
    step_t s;
    s = '0;
    s.item.opcode = OPC_REQUEST;
    s.item.size_value = sz;
    return s;
  endfunction

  function automatic step_t rq_lit(input logic [SIZE_BITS-1:0] sz, input out_item_t lit);
    step_t s;
    s = rq(sz);
    s.has_lit = 1'b1;
    s.lit = lit;
    return s;
  endfunction

  // Sizes lean towards small values and the two extremes. This gives plenty
  // of grants, refusals and tied leftovers.
  function automatic logic [SIZE_BITS-1:0] draw_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return SIZE_BITS'($urandom_range(0, 255));
      4: return SIZE_BITS'($urandom_range(0, 4095));
      default: return SIZE_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t draw_item();
    in_item_t it;
    it.opcode = ($urandom_range(0, 99) < 40) ? OPC_LOAD : OPC_REQUEST;
    it.block_index = IDX_BITS'($urandom_range(0, NUM_BLOCKS - 1));
    it.size_value = draw_size();
    return it;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] draw_count();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_BITS'(0);
      1: return CFG_DATA_BITS'(1);
      2: return CFG_DATA_BITS'(2);
      3: return CFG_DATA_BITS'(NUM_BLOCKS);
      4: return '1;
      5: return CFG_DATA_BITS'($urandom_range(NUM_BLOCKS + 1, 30));
      default: return CFG_DATA_BITS'($urandom_range(3, NUM_BLOCKS - 1));
    endcase
  endfunction

  initial begin
    step_t    plan [$];
    in_item_t it;
    int       b;
    bit       first_phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Partitions 0 to 3 and 15 are loaded; the count stays at four or below.
    plan = '{
      cf(CFG_BLOCKS_IN_USE, CFG_DATA_BITS'(4)),
      ld(0, 16'd100), ld(1, 16'hFFFF), ld(2, 16'd0), ld(3, 16'd300), ld(15, 16'hA5A5),
      // First fit after reset, from the largest request down to a refusal.
      rq_lit(16'hFFFF, out_item_t'{1'b1, 4'd1, 16'hFFFF, 16'd0}),
      rq_lit(16'd0, out_item_t'{1'b1, 4'd0, 16'd100, 16'd100}),
      rq_lit(16'd0, out_item_t'{1'b1, 4'd2, 16'd0, 16'd0}),
      rq_lit(16'hFFFF, REFUSED),
      rq(16'd300),
      rq_lit(16'd1, REFUSED),
      // Next fit walks forward from its pointer and wraps back to zero.
      cf(CFG_FIT_POLICY, CFG_DATA_BITS'(POL_NEXT)),
      ld(0, 16'd100), ld(1, 16'd200), ld(2, 16'd300), ld(3, 16'd400),
      rq(16'd250), rq(16'd50), rq(16'd50),
      // Worst fit, then two equal leftovers where the lower index must win.
      cf(CFG_FIT_POLICY, CFG_DATA_BITS'(POL_WORST)),
      ld(3, 16'd400), rq(16'd10), ld(0, 16'd200), rq(16'd50),
      cf(CFG_FIT_POLICY, CFG_DATA_BITS'(POL_SPARE)),
      rq(16'd0),
      // With no partitions in the search, every request is refused.
      cf(CFG_BLOCKS_IN_USE, CFG_DATA_BITS'(0)),
      rq_lit(16'd0, REFUSED),
      // The pointer is left on partition 3 and the count then drops to two.
      cf(CFG_FIT_POLICY, CFG_DATA_BITS'(POL_NEXT)),
      cf(CFG_BLOCKS_IN_USE, CFG_DATA_BITS'(4)),
      ld(3, 16'd50), rq(16'd50), ld(1, 16'd70),
      cf(CFG_BLOCKS_IN_USE, CFG_DATA_BITS'(2)),
      rq(16'd10)
    };
    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].reg_idx, plan[k].reg_val);
      else send(plan[k].item, plan[k].has_lit, plan[k].lit);
    end

    // Every partition is written before the first random request.
    for (b = 0; b < NUM_BLOCKS; b++) begin
      it.opcode = OPC_LOAD;
      it.block_index = IDX_BITS'(b);
      it.size_value = draw_size();
      send(it, 1'b0, '0);
    end

    // Each phase starts idle: the sender holds off until every grant is in.
    // The first phase uses a count above the number of partitions.
    first_phase = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      write_reg(CFG_FIT_POLICY, CFG_DATA_BITS'($urandom_range(0, 3)));
      write_reg(CFG_BLOCKS_IN_USE, first_phase ? '1 : draw_count());
      first_phase = 1'b0;
      calm_tx = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 60)) send(draw_item(), 1'b0, '0);
    end
    drain();

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

endmodule
